### rtl/ibma_pkg.sv
// shared constants, types and helper functions of the id bitmap allocator
package ibma_pkg;

   localparam int ID_COUNT      = 1024;
   localparam int MAP_WORD_BITS = 32;
   localparam int MAP_WORDS     = (ID_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

   localparam int ID_W     = 16;
   localparam int FUNC_W   = 1;
   localparam int STATUS_W = 2;

   // bit position within a map row; rows are a power of two wide
   localparam int BIT_W   = $clog2(MAP_WORD_BITS);
   localparam int ROW_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int LIMIT_W = $clog2(ID_COUNT + 1);
   localparam int REM_W   = $clog2(((ID_COUNT > MAP_WORD_BITS) ? ID_COUNT : MAP_WORD_BITS) + 1);

   localparam logic [ID_W-1:0] FIRST_ID_RESET = ID_W'(100);

   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef logic [MAP_WORD_BITS-1:0] row_type;
   typedef logic [ROW_W-1:0]         row_addr_type;
   typedef logic [LIMIT_W-1:0]       limit_type;

   typedef struct packed {
      logic         rd_en;
      row_addr_type rd_addr;
      logic         wr_en;
      row_addr_type wr_addr;
      row_type      wr_data;
   } map_req_type;

   // number of slots whose id stays inside the 16-bit id space
   function automatic limit_type usable_slots(input logic [ID_W-1:0] first_id);
      logic [ID_W:0] room;
      room = (ID_W+1)'(1 << ID_W) - {1'b0, first_id};
      if (room < (ID_W+1)'(ID_COUNT)) begin
         return LIMIT_W'(room);
      end
      return LIMIT_W'(ID_COUNT);
   endfunction

   // index of the lowest set bit, zero when none is set
   function automatic logic [BIT_W-1:0] lowest_set(input row_type vec);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

### rtl/ibma_map.sv
// bitmap store: one row per address, row valid flags cleared at reset
module ibma_map (
   input  logic                 clock,
   input  logic                 reset,
   input  ibma_pkg::map_req_type req,
   output ibma_pkg::row_type    rd_row
);

   ibma_pkg::row_type                 mem [ibma_pkg::MAP_WORDS];
   logic [ibma_pkg::MAP_WORDS-1:0]    row_valid_ff;
   ibma_pkg::row_type                 rd_data_ff;
   logic                              rd_ok_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   // a row never written reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_ok_ff     <= 1'b0;
      end else begin
         if (req.wr_en) begin
            row_valid_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_ok_ff <= row_valid_ff[req.rd_addr];
         end
      end
   end

   assign rd_row = rd_ok_ff ? rd_data_ff : '0;

endmodule

### rtl/ibma_seq.sv
// request sequencer: row-by-row free slot scan and release read-modify-write
module ibma_seq (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [ibma_pkg::FUNC_W-1:0]           func,
   input  logic [ibma_pkg::ID_W-1:0]             release_id,
   input  logic [ibma_pkg::ID_W-1:0]             first_id,
   input  ibma_pkg::limit_type                   limit,
   output ibma_pkg::map_req_type                 map_req,
   input  ibma_pkg::row_type                     rd_row,
   output logic                                  rsp_valid,
   output logic [ibma_pkg::ID_W-1:0]             rsp_granted_id,
   output logic [ibma_pkg::STATUS_W-1:0]         rsp_status
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_CLEAR = 2'd2;

   logic [1:0]                        state_ff, state_in;
   ibma_pkg::row_addr_type            row_ff, row_in;
   logic [ibma_pkg::BIT_W-1:0]        bit_ff, bit_in;
   logic [ibma_pkg::REM_W-1:0]        remain_ff, remain_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ibma_pkg::ID_W-1:0]         granted_ff, granted_in;
   logic [ibma_pkg::STATUS_W-1:0]     status_ff, status_in;

   logic [ibma_pkg::ID_W:0]           offset;
   logic                              in_range;
   ibma_pkg::row_addr_type            rel_row;
   logic [ibma_pkg::BIT_W-1:0]        rel_bit;
   ibma_pkg::row_type                 usable_mask;
   ibma_pkg::row_type                 free_bits;
   logic [ibma_pkg::BIT_W-1:0]        free_bit;
   logic                              last_row;

   // release id check: borrow means below the pool
   assign offset   = {1'b0, release_id} - {1'b0, first_id};
   assign in_range = !offset[ibma_pkg::ID_W] &&
                     (offset < (ibma_pkg::ID_W+1)'(limit));
   assign rel_row  = ibma_pkg::ROW_W'(offset[ibma_pkg::ID_W-1:0] >> ibma_pkg::BIT_W);
   assign rel_bit  = offset[ibma_pkg::BIT_W-1:0];

   // slots of the current row that lie inside the usable pool
   assign last_row    = remain_ff <= ibma_pkg::REM_W'(ibma_pkg::MAP_WORD_BITS);
   assign usable_mask = (remain_ff >= ibma_pkg::REM_W'(ibma_pkg::MAP_WORD_BITS)) ? '1 :
                        ((ibma_pkg::MAP_WORD_BITS)'(1) << remain_ff[ibma_pkg::BIT_W-1:0])
                        - (ibma_pkg::MAP_WORD_BITS)'(1);
   assign free_bits   = ~rd_row & usable_mask;
   assign free_bit    = ibma_pkg::lowest_set(free_bits);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      bit_in       = bit_ff;
      remain_in    = remain_ff;
      rsp_valid_in = 1'b0;
      granted_in   = granted_ff;
      status_in    = status_ff;
      map_req      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (func == ibma_pkg::FUNC_ALLOC) begin
                  map_req.rd_en   = 1'b1;
                  map_req.rd_addr = '0;
                  row_in          = '0;
                  remain_in       = ibma_pkg::REM_W'(limit);
                  state_in        = ST_SCAN;
               end else if (in_range) begin
                  map_req.rd_en   = 1'b1;
                  map_req.rd_addr = rel_row;
                  row_in          = rel_row;
                  bit_in          = rel_bit;
                  state_in        = ST_CLEAR;
               end else begin
                  rsp_valid_in = 1'b1;
                  granted_in   = '0;
                  status_in    = ibma_pkg::STATUS_RANGE;
               end
            end
         end
         ST_SCAN: begin
            if (|free_bits) begin
               map_req.wr_en   = 1'b1;
               map_req.wr_addr = row_ff;
               map_req.wr_data = rd_row | ((ibma_pkg::MAP_WORD_BITS)'(1) << free_bit);
               rsp_valid_in    = 1'b1;
               granted_in      = ibma_pkg::ID_W'(first_id +
                                 ibma_pkg::ID_W'({row_ff, free_bit}));
               status_in       = ibma_pkg::STATUS_OK;
               state_in        = ST_IDLE;
            end else if (last_row) begin
               rsp_valid_in = 1'b1;
               granted_in   = '0;
               status_in    = ibma_pkg::STATUS_FULL;
               state_in     = ST_IDLE;
            end else begin
               // fetch the next row while this one is checked
               map_req.rd_en   = 1'b1;
               map_req.rd_addr = row_ff + ibma_pkg::ROW_W'(1);
               row_in          = row_ff + ibma_pkg::ROW_W'(1);
               remain_in       = remain_ff - ibma_pkg::REM_W'(ibma_pkg::MAP_WORD_BITS);
            end
         end
         ST_CLEAR: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = row_ff;
            map_req.wr_data = rd_row & ~((ibma_pkg::MAP_WORD_BITS)'(1) << bit_ff);
            rsp_valid_in    = 1'b1;
            granted_in      = '0;
            status_in       = ibma_pkg::STATUS_OK;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      bit_ff     <= bit_in;
      remain_ff  <= remain_in;
      granted_ff <= granted_in;
      status_ff  <= status_in;
   end

   assign busy           = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = granted_ff;
   assign rsp_status     = status_ff;

endmodule

### rtl/id_bitmap_allocator_top.sv
// top level of the id bitmap allocator: config register, sequencer and bitmap store
//
// hands out ids first_id .. first_id + pool - 1 from a bitmap of in-use slots,
// pool = min(ID_COUNT, 65536 - first_id). a word is taken when start is high and
// busy is low; each word gives exactly one result, strobed by rsp_valid for a
// single cycle, and the receiver cannot stall it, so sample it when it shows.
// allocate scans the bitmap one row of MAP_WORD_BITS slots per cycle from the
// lowest row and stops at the first row with a free slot; a full pool answers
// once the last row of the pool is checked. release is one row read, then one
// row write; a release outside the pool is answered with no bitmap access.
// the scan rate is set by the single read port of the bitmap store. a new word can
// be taken in the very cycle the previous result is strobed. the bitmap reads as
// all free after reset with no clearing pass. first_id is taken only while busy
// and start are both low; ids handed out earlier keep their slot and take the
// new base.
module id_bitmap_allocator_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ibma_pkg::FUNC_W-1:0]        req_func,
   input  logic [ibma_pkg::ID_W-1:0]          req_release_id,
   output logic                               rsp_valid,
   output logic [ibma_pkg::ID_W-1:0]          rsp_granted_id,
   output logic [ibma_pkg::STATUS_W-1:0]      rsp_status,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ibma_pkg::ID_W-1:0]          csr_first_id
);

   // base id and the matching pool size, kept together so the
   // sequencer never has to work the limit out per request
   logic [ibma_pkg::ID_W-1:0]   first_id_ff, first_id_in;
   ibma_pkg::limit_type         limit_ff, limit_in;

   ibma_pkg::map_req_type       map_req;
   ibma_pkg::row_type           rd_row;

   // config word only while no request is in flight or being taken
   assign csr_ready = !busy && !start;

   always_comb begin
      first_id_in = first_id_ff;
      limit_in    = limit_ff;
      if (csr_valid && csr_ready) begin
         first_id_in = csr_first_id;
         limit_in    = ibma_pkg::usable_slots(csr_first_id);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_id_ff <= ibma_pkg::FIRST_ID_RESET;
         limit_ff    <= ibma_pkg::usable_slots(ibma_pkg::FIRST_ID_RESET);
      end else begin
         first_id_ff <= first_id_in;
         limit_ff    <= limit_in;
      end
   end

   // request sequencer: scan, mark and clear
   ibma_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .func           (req_func),
      .release_id     (req_release_id),
      .first_id       (first_id_ff),
      .limit          (limit_ff),
      .map_req        (map_req),
      .rd_row         (rd_row),
      .rsp_valid      (rsp_valid),
      .rsp_granted_id (rsp_granted_id),
      .rsp_status     (rsp_status)
   );

   // bitmap rows, registered read
   ibma_map u_map (
      .clock  (clock),
      .reset  (reset),
      .req    (map_req),
      .rd_row (rd_row)
   );

endmodule

### rtl/ibma_checker.sv
// port-level checks of the id bitmap allocator and their bind
module ibma_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic [ibma_pkg::ID_W-1:0]          rsp_granted_id,
   input logic [ibma_pkg::STATUS_W-1:0]      rsp_status,
   input logic                               csr_ready
);

   // a taken word either keeps the block busy or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted word neither in progress nor answered");

   // no result without a word in flight the cycle before
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start && !busy)))
      else $error("result strobed with no word in flight");

   // only the three defined status codes, and no id on a failure
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ibma_pkg::STATUS_OK ||
                     rsp_status == ibma_pkg::STATUS_FULL ||
                     rsp_status == ibma_pkg::STATUS_RANGE))
      else $error("undefined status code");

   a_fail_zero_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ibma_pkg::STATUS_OK) |-> (rsp_granted_id == '0))
      else $error("id given with a failure status");

   // config writes only taken while idle
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !busy)
      else $error("config port ready while busy");

endmodule

bind id_bitmap_allocator_top ibma_checker u_chk (.*);

### test/id_bitmap_allocator_top_tb.sv
// self-checking testbench of the id bitmap allocator top level
`timescale 1ns / 1ps

module id_bitmap_allocator_top_tb;

   import ibma_pkg::*;

   // one request word and one response word, at the widths of the ports
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   release_id;
   } id_request_type;

   typedef struct packed {
      logic [ID_W-1:0]     granted_id;
      logic [STATUS_W-1:0] status;
   } id_response_type;

   logic                clock;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic                busy;
   logic [FUNC_W-1:0]   req_func       = FUNC_ALLOC;
   logic [ID_W-1:0]     req_release_id = '0;
   logic                rsp_valid;
   logic [ID_W-1:0]     rsp_granted_id;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_valid      = 1'b0;
   logic                csr_ready;
   logic [ID_W-1:0]     csr_first_id   = '0;

   id_bitmap_allocator_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_release_id (req_release_id),
      .rsp_valid      (rsp_valid),
      .rsp_granted_id (rsp_granted_id),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_first_id   (csr_first_id)
   );

   // own copy of the allocator state: one bit per slot, set while in use
   logic [ID_COUNT-1:0] slot_busy = '0;
   logic [ID_W-1:0]     base_id   = FIRST_ID_RESET;

   id_request_type  pending_q[$];       // words waiting for the driver
   id_response_type grant_status_q[$];  // responses owed by the block, oldest first

   int send_idle_pct = 0;
   int error_count   = 0;
   int ok_seen       = 0;
   int full_seen     = 0;
   int range_seen    = 0;
   int base_writes   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // slots whose id still fits in 16 bits under the current base
   function automatic int unsigned pool_size();
      int unsigned room;
      room = 32'd65536 - base_id;
      return (room < ID_COUNT) ? room : ID_COUNT;
   endfunction

   // lowest-free-slot allocation and range-checked release on the shadow map
   function automatic id_response_type apply_request(id_request_type w);
      id_response_type r;
      int unsigned     pool;
      int unsigned     rid;
      int unsigned     b;
      logic            found;
      r.granted_id = '0;
      r.status     = STATUS_OK;
      pool         = pool_size();
      rid          = w.release_id;
      b            = base_id;
      found        = 1'b0;
      if (w.func == FUNC_ALLOC) begin
         r.status = STATUS_FULL;
         for (int k = 0; k < pool; k++) begin
            if (!found && !slot_busy[k]) begin
               found        = 1'b1;
               slot_busy[k] = 1'b1;
               r.granted_id = ID_W'(b + k);
               r.status     = STATUS_OK;
            end
         end
      end else if (rid < b || rid - b >= pool) begin
         r.status = STATUS_RANGE;
      end else begin
         // releasing a slot that is already free is fine, the bit just stays clear
         slot_busy[rid - b] = 1'b0;
      end
      return r;
   endfunction

   // random request word; releases mostly aim at the packed low end of the map
   function automatic id_request_type make_request(int alloc_pct);
      id_request_type w;
      int unsigned    pool;
      int unsigned    used;
      int unsigned    hi;
      int unsigned    pick;
      w.func       = FUNC_ALLOC;
      w.release_id = ID_W'($urandom);
      if ($urandom_range(0, 99) < alloc_pct) begin
         return w;
      end
      w.func = FUNC_RELEASE;
      pool   = pool_size();
      used   = $countones(slot_busy);
      hi     = (used + 3 < pool) ? used + 3 : pool - 1;
      pick   = $urandom_range(0, 99);
      if (pick < 75) begin
         w.release_id = ID_W'(base_id + $urandom_range(0, hi));
      end else if (pick < 90) begin
         // outside the pool, above or below
         if (base_id + pool <= 65535 && (base_id == 0 || $urandom_range(0, 1) == 1)) begin
            w.release_id = ID_W'($urandom_range(base_id + pool, 65535));
         end else if (base_id > 0) begin
            w.release_id = ID_W'($urandom_range(0, base_id - 1));
         end
      end
      return w;
   endfunction

   // driver: a word is taken at an edge with start high and busy low, and its
   // response is predicted there; start holds while busy, else the next word
   // goes out unless this cycle is picked as a gap
   always @(posedge clock) begin : req_drive
      id_request_type cur;
      id_request_type nxt;
      cur.func       = req_func;
      cur.release_id = req_release_id;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            grant_status_q.push_back(apply_request(cur));
         end
         if (start && busy) begin
            // word still waiting to be taken, keep everything as it is
         end else if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = pending_q.pop_front();
            start          <= 1'b1;
            req_func       <= nxt.func;
            req_release_id <= nxt.release_id;
         end else begin
            // idle: junk on the request fields must be ignored
            start          <= 1'b0;
            req_func       <= FUNC_W'($urandom);
            req_release_id <= ID_W'($urandom);
         end
      end
   end

   // monitor: every strobed response is matched against the oldest prediction
   always @(posedge clock) begin : rsp_check
      id_response_type want;
      if (!reset && rsp_valid) begin
         if (grant_status_q.size() == 0) begin
            $error("response with none outstanding: granted_id %0d status %0d",
                   rsp_granted_id, rsp_status);
            error_count++;
         end else begin
            want = grant_status_q.pop_front();
            if (rsp_granted_id !== want.granted_id) begin
               $error("granted_id mismatch: expected %0d, actual %0d",
                      want.granted_id, rsp_granted_id);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
            case (want.status)
               STATUS_FULL:  full_seen++;
               STATUS_RANGE: range_seen++;
               default:      ok_seen++;
            endcase
         end
      end
   end

   function automatic id_request_type word_of(logic [FUNC_W-1:0] f, logic [ID_W-1:0] rid);
      id_request_type w;
      w.func       = f;
      w.release_id = rid;
      return w;
   endfunction

   // wait until every word is taken and answered, then a short settle
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_q.size() != 0 || start || grant_status_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // base id write, only ever issued with the block idle
   task automatic write_first_id(logic [ID_W-1:0] v);
      @(posedge clock);
      csr_valid    <= 1'b1;
      csr_first_id <= v;
      do @(posedge clock);
      while (!csr_ready);
      base_id = v;
      base_writes++;
      csr_valid <= 1'b0;
   endtask

   // feeds the driver, keeping at most two words queued, so releases see a nearly up-to-date map
   task automatic run_random(int count, int alloc_pct, int idle_pct);
      send_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         do @(negedge clock);
         while (pending_q.size() >= 2);
         pending_q.push_back(make_request(alloc_pct));
      end
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, reset base of 100: pool is ids 100 .. 1123
      send_idle_pct = 0;
      pending_q.push_back(word_of(FUNC_ALLOC, 16'hFFFF));
      pending_q.push_back(word_of(FUNC_ALLOC, 16'h0000));
      pending_q.push_back(word_of(FUNC_ALLOC, 16'h5A5A));
      pending_q.push_back(word_of(FUNC_RELEASE, 16'd101));   // middle id goes back
      pending_q.push_back(word_of(FUNC_ALLOC, 16'hA5A5));    // lowest free is 101 again
      pending_q.push_back(word_of(FUNC_RELEASE, 16'd99));    // one below the pool
      pending_q.push_back(word_of(FUNC_RELEASE, 16'd0));
      pending_q.push_back(word_of(FUNC_RELEASE, 16'd1124));  // one above the pool
      pending_q.push_back(word_of(FUNC_RELEASE, 16'hFFFF));
      pending_q.push_back(word_of(FUNC_RELEASE, 16'd1123));  // top slot, already free
      pending_q.push_back(word_of(FUNC_RELEASE, 16'd100));
      pending_q.push_back(word_of(FUNC_RELEASE, 16'd100));   // same slot twice
      pending_q.push_back(word_of(FUNC_ALLOC, 16'h8000));
      pending_q.push_back(word_of(FUNC_RELEASE, 16'd102));
      pending_q.push_back(word_of(FUNC_RELEASE, 16'd101));
      wait_drained();

      // base of zero, back to back
      write_first_id(16'd0);
      run_random(40, 60, 0);

      // pool cut short by the 16-bit id space: 36 slots, fills up quickly
      write_first_id(16'd65500);
      run_random(50, 55, 58);

      // a single slot whose id is 65535
      write_first_id(16'hFFFF);
      pending_q.push_back(word_of(FUNC_ALLOC, 16'd0));
      pending_q.push_back(word_of(FUNC_ALLOC, 16'd0));
      pending_q.push_back(word_of(FUNC_RELEASE, 16'hFFFE));
      pending_q.push_back(word_of(FUNC_RELEASE, 16'hFFFF));
      run_random(16, 50, 36);

      write_first_id(ID_W'($urandom_range(1, 64511)));
      run_random(40, 50, 58);

      // highest base with a full-size pool; allocate only, so the whole map
      // fills and the last requests get full answers after the longest scan
      write_first_id(16'd64512);
      run_random(1030, 100, 36);

      // back to the reset base, releases and allocations on a full map
      write_first_id(FIRST_ID_RESET);
      run_random(30, 40, 0);

      repeat (MAP_WORDS + 8) @(posedge clock);
      $display("summary: %0d responses checked under %0d base id settings,",
               ok_seen + full_seen + range_seen, base_writes);
      $display("summary: overflowing pools among them; %0d ok, %0d pool full, %0d out of pool",
               ok_seen, full_seen, range_seen);
      if (error_count == 0) begin
         $display("** id_bitmap_allocator_top: PASSED **");
      end else begin
         $display("** id_bitmap_allocator_top: FAILED **");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("timeout: %0d words pending, %0d responses owed",
               pending_q.size(), grant_status_q.size());
      $display("** id_bitmap_allocator_top: FAILED **");
      $finish;
   end

endmodule

### filelist.f
rtl/ibma_pkg.sv
rtl/ibma_map.sv
rtl/ibma_seq.sv
rtl/id_bitmap_allocator_top.sv
rtl/ibma_checker.sv
test/id_bitmap_allocator_top_tb.sv
